### rtl/core/arpr_pkg.sv
// Shared types, constants and the reply byte lookup for the ARP proxy responder.
// No dependencies.
package arpr_pkg;

    localparam int MAX_IPS_DEF = 4;
    localparam int FRAME_LEN   = 42;
    localparam int IDX_W       = 6;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;

    localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN       = 8'd6;
    localparam logic [7:0]  ARP_PLEN       = 8'd4;

    // register indexes, byte address is 8 * index
    localparam logic [2:0] REG_IP_ENTRY_0  = 3'd0;
    localparam logic [2:0] REG_IP_ENTRY_3  = 3'd3;
    localparam logic [2:0] REG_IP_COUNT    = 3'd4;
    localparam logic [2:0] REG_REPLY_MAC   = 3'd5;
    localparam logic [2:0] REG_REPLIES_EN  = 3'd6;

    typedef enum logic [2:0] {
        ST_REPLY   = 3'd0,
        ST_NOT_ARP = 3'd1,
        ST_NOT_REQ = 3'd2,
        ST_IP_MISS = 3'd3,
        ST_DRY_RUN = 3'd4,
        ST_SHORT   = 3'd5
    } status_t;

    typedef struct packed {
        logic [2:0]  ip_count;
        logic [47:0] reply_mac;
        logic        replies_en;
    } cfg_t;

    typedef struct packed {
        logic        go;
        status_t     status;
        logic [47:0] smac;
        logic [31:0] sip;
        logic [31:0] tip;
    } launch_t;

    // byte k of the reply frame, destination MAC first
    function automatic logic [7:0] reply_byte(
        input logic [IDX_W-1:0] k,
        input logic [47:0]      smac,
        input logic [47:0]      rmac,
        input logic [31:0]      sip,
        input logic [31:0]      tip
    );
        logic [8*FRAME_LEN-1:0] frame;
        logic [8:0]             off;
        frame = {smac, rmac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ARP_PTYPE_IPV4,
                 ARP_HLEN, ARP_PLEN, ARP_OP_REPLY, rmac, tip, smac, sip};
        off = 9'(8 * (FRAME_LEN - 1)) - {k, 3'b000};
        if (k < IDX_W'(FRAME_LEN))
            return frame[off +: 8];
        else
            return 8'h00;
    endfunction

endpackage

### rtl/core/arpr_regs.sv
// APB-style configuration registers: handled addresses, count, reply MAC, enable.
// Depends on arpr_pkg.
module arpr_regs
    import arpr_pkg::*;
#(
    parameter int MAX_IPS = MAX_IPS_DEF
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [CFG_ADDR_W-1:0]            paddr,
    input  logic [CFG_DATA_W-1:0]            pwdata,
    output logic [CFG_DATA_W-1:0]            prdata,
    output logic                             pready,
    output logic [MAX_IPS-1:0][31:0]         ip_entry,
    output cfg_t                             cfg
);

    logic [MAX_IPS-1:0][31:0] ip_entry_reg;
    logic [2:0]               ip_count_reg;
    logic [47:0]              reply_mac_reg;
    logic                     replies_en_reg;
    logic [2:0]               reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_entry_reg   <= '0;
            ip_count_reg   <= '0;
            reply_mac_reg  <= '0;
            replies_en_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            if (reg_idx <= REG_IP_ENTRY_3)
            begin
                // entries beyond MAX_IPS are never compared, so not stored
                for (int i = 0; i < MAX_IPS; i++)
                begin
                    if (reg_idx == 3'(i))
                        ip_entry_reg[i] <= pwdata[31:0];
                end
            end
            else if (reg_idx == REG_IP_COUNT)
                ip_count_reg <= pwdata[2:0];
            else if (reg_idx == REG_REPLY_MAC)
                reply_mac_reg <= pwdata[47:0];
            else if (reg_idx == REG_REPLIES_EN)
                replies_en_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx <= REG_IP_ENTRY_3)
        begin
            for (int i = 0; i < MAX_IPS; i++)
            begin
                if (reg_idx == 3'(i))
                    prdata = {32'd0, ip_entry_reg[i]};
            end
        end
        else if (reg_idx == REG_IP_COUNT)
            prdata = {61'd0, ip_count_reg};
        else if (reg_idx == REG_REPLY_MAC)
            prdata = {16'd0, reply_mac_reg};
        else if (reg_idx == REG_REPLIES_EN)
            prdata = {63'd0, replies_en_reg};
    end

    assign ip_entry       = ip_entry_reg;
    assign cfg.ip_count   = ip_count_reg;
    assign cfg.reply_mac  = reply_mac_reg;
    assign cfg.replies_en = replies_en_reg;

endmodule

### rtl/core/arpr_parse.sv
// Frame parser: captures header fields by offset and decides the outcome at frame end.
// Depends on arpr_pkg.
module arpr_parse
    import arpr_pkg::*;
#(
    parameter int MAX_IPS = MAX_IPS_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               rx_byte,
    input  logic                     frame_end,
    input  logic [MAX_IPS-1:0][31:0] ip_entry,
    input  cfg_t                     cfg,
    input  logic                     launch_ok,
    output launch_t                  launch
);

    logic [IDX_W-1:0] idx_reg,  idx_next;
    logic [15:0]      eth_reg,  eth_next;
    logic [15:0]      op_reg,   op_next;
    logic [47:0]      smac_reg, smac_next;
    logic [31:0]      sip_reg,  sip_next;
    logic [31:0]      tip_reg,  tip_next;
    logic [2:0]       n_eff;
    logic             hit;
    logic             accept;
    status_t          status;

    // a frame end beat waits until the result side can take a new outcome
    assign in_ready = !frame_end || launch_ok;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        idx_next  = idx_reg;
        eth_next  = eth_reg;
        op_next   = op_reg;
        smac_next = smac_reg;
        sip_next  = sip_reg;
        tip_next  = tip_reg;
        if (idx_reg < IDX_W'(FRAME_LEN))
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == 6'd12 || idx_reg == 6'd13)
                eth_next = {eth_reg[7:0], rx_byte};
            else if (idx_reg == 6'd20 || idx_reg == 6'd21)
                op_next = {op_reg[7:0], rx_byte};
            else if (idx_reg >= 6'd22 && idx_reg < 6'd28)
                smac_next = {smac_reg[39:0], rx_byte};
            else if (idx_reg >= 6'd28 && idx_reg < 6'd32)
                sip_next = {sip_reg[23:0], rx_byte};
            else if (idx_reg >= 6'd38)
                tip_next = {tip_reg[23:0], rx_byte};
        end
    end

    always_comb
    begin
        n_eff = (cfg.ip_count > 3'(MAX_IPS)) ? 3'(MAX_IPS) : cfg.ip_count;
        hit   = 1'b0;
        for (int i = 0; i < MAX_IPS; i++)
        begin
            if (3'(i) < n_eff && ip_entry[i] == tip_next)
                hit = 1'b1;
        end
        priority if (idx_next < IDX_W'(FRAME_LEN))
            status = ST_SHORT;
        else if (eth_next != ETH_TYPE_ARP)
            status = ST_NOT_ARP;
        else if (op_next != ARP_OP_REQUEST)
            status = ST_NOT_REQ;
        else if (!hit)
            status = ST_IP_MISS;
        else if (!cfg.replies_en)
            status = ST_DRY_RUN;
        else
            status = ST_REPLY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (accept)
            idx_reg <= frame_end ? '0 : idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eth_reg  <= '0;
            op_reg   <= '0;
            smac_reg <= '0;
            sip_reg  <= '0;
            tip_reg  <= '0;
        end
        else if (accept)
        begin
            eth_reg  <= eth_next;
            op_reg   <= op_next;
            smac_reg <= smac_next;
            sip_reg  <= sip_next;
            tip_reg  <= tip_next;
        end
    end

    assign launch.go     = accept && frame_end;
    assign launch.status = status;
    assign launch.smac   = smac_next;
    assign launch.sip    = sip_next;
    assign launch.tip    = tip_next;

endmodule

### rtl/core/arpr_tx.sv
// Result register and reply sequencer: one status beat or the 42 reply beats.
// Depends on arpr_pkg.
module arpr_tx
    import arpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  launch_t     launch,
    input  logic [47:0] reply_mac,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  tx_byte,
    output logic [2:0]  status,
    output logic        last,
    output logic        launch_ok
);

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] k_reg,         k_next;
    logic [7:0]       tx_byte_reg,   tx_byte_next;
    status_t          status_reg,    status_next;
    logic             last_reg,      last_next;
    logic [47:0]      smac_reg,      smac_next;
    logic [31:0]      sip_reg,       sip_next;
    logic [31:0]      tip_reg,       tip_next;
    logic             taken;

    assign taken     = out_valid_reg && out_ready;
    assign launch_ok = !out_valid_reg || (out_ready && last_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        tx_byte_next   = tx_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        smac_next      = smac_reg;
        sip_next       = sip_reg;
        tip_next       = tip_reg;
        priority if (launch.go)
        begin
            // snapshot, the parser overwrites its fields with the next frame
            out_valid_next = 1'b1;
            k_next         = '0;
            status_next    = launch.status;
            smac_next      = launch.smac;
            sip_next       = launch.sip;
            tip_next       = launch.tip;
            if (launch.status == ST_REPLY)
            begin
                tx_byte_next = reply_byte('0, launch.smac, reply_mac, launch.sip, launch.tip);
                last_next    = 1'b0;
            end
            else
            begin
                tx_byte_next = 8'h00;
                last_next    = 1'b1;
            end
        end
        else if (taken && last_reg)
            out_valid_next = 1'b0;
        else if (taken)
        begin
            k_next       = k_reg + 1'b1;
            tx_byte_next = reply_byte(k_next, smac_reg, reply_mac, sip_reg, tip_reg);
            last_next    = (k_next == IDX_W'(FRAME_LEN - 1));
        end
        else
        begin
            // idle or held by the receiver: everything keeps its value
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg <= tx_byte_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        smac_reg    <= smac_next;
        sip_reg     <= sip_next;
        tip_reg     <= tip_next;
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef ASSERT_OFF
    a_status_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_REPLY |-> last_reg && tx_byte_reg == 8'h00)
        else $error("status beat without last or with data");

    a_reply_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_REPLY |->
            last_reg == (k_reg == IDX_W'(FRAME_LEN - 1)))
        else $error("reply last flag misplaced");

    a_launch_room: assert property (@(posedge clk) disable iff (!rst_n)
        launch.go |-> !out_valid_reg || (out_ready && last_reg))
        else $error("outcome launched over pending results");

    a_reply_advance: assert property (@(posedge clk) disable iff (!rst_n)
        taken && !last_reg && !launch.go |=> out_valid_reg && k_reg == $past(k_reg) + 1'b1)
        else $error("reply sequencer did not advance");
`endif

endmodule

### rtl/core/arp_proxy_responder.sv
// Top level of the ARP proxy responder: config registers, parser and reply sequencer.
// Depends on arpr_pkg, arpr_regs, arpr_parse, arpr_tx.
//
// Received frame bytes are taken one per cycle, destination MAC first, with
// frame_end on the final byte. Mid-frame bytes are never stalled. At frame end
// the outcome is decided in the same cycle: either one status beat, or a
// 42-beat ARP reply in which reply_mac answers for the target IP, presented one
// byte per cycle while out_ready is high, from the output register. A frame end
// beat is held off only while results of the previous frame are still queued,
// and is accepted in the cycle that the previous frame's final beat is taken.
// Configuration is held in flip-flops; there is no clearing pass after reset.
// Registers sit at byte address 8 * index on a 64-bit port.
module arp_proxy_responder
    import arpr_pkg::*;
#(
    parameter int MAX_IPS = MAX_IPS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            tx_byte,
    output logic [2:0]            status,
    output logic                  last
);

    logic [MAX_IPS-1:0][31:0] ip_entry;
    cfg_t                     cfg;
    launch_t                  launch;
    logic                     launch_ok;

    arpr_regs #(
        .MAX_IPS (MAX_IPS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ip_entry (ip_entry),
        .cfg      (cfg)
    );

    arpr_parse #(
        .MAX_IPS (MAX_IPS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .ip_entry  (ip_entry),
        .cfg       (cfg),
        .launch_ok (launch_ok),
        .launch    (launch)
    );

    arpr_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (launch),
        .reply_mac (cfg.reply_mac),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .tx_byte   (tx_byte),
        .status    (status),
        .last      (last),
        .launch_ok (launch_ok)
    );

endmodule

### tb/arp_proxy_checker.sv
// Scoreboard for the ARP proxy responder: mirrors register writes, predicts each
// output beat from the accepted frame bytes and compares them in order.
// Depends on arpr_pkg.
module arp_proxy_checker
    import arpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_end,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [7:0]            tx_byte,
    input  logic [2:0]            status,
    input  logic                  last,
    output int                    errors,
    output int                    pending,
    output int                    replies_seen,
    output int                    refusals_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // frame offsets of the captured fields
    localparam int OFS_ETYPE   = 12;
    localparam int OFS_OPER    = 20;
    localparam int OFS_SHA     = 22;
    localparam int OFS_SPA     = 28;
    localparam int OFS_TPA     = 38;

    typedef struct packed {
        logic [7:0] data;
        status_t    code;
        logic       lst;
    } tx_beat_t;

    tx_beat_t    owed_beats[$];
    logic [7:0]  reply_img[$];

    // register mirror
    logic [31:0] ip_tab[4];
    logic [2:0]  ip_used;
    logic [47:0] my_mac;
    logic        reply_on;

    // parser mirror
    int          rx_count;
    logic [15:0] cap_etype;
    logic [15:0] cap_oper;
    logic [47:0] cap_sha;
    logic [31:0] cap_spa;
    logic [31:0] cap_tpa;

    task automatic mismatch(input string field, input logic [63:0] want,
                            input logic [63:0] got);
        errors++;
        $error("%s: expected %0h, got %0h", field, want, got);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
        if (idx <= REG_IP_ENTRY_3)
            ip_tab[idx[1:0]] = v[31:0];
        else if (idx == REG_IP_COUNT)
            ip_used = v[2:0];
        else if (idx == REG_REPLY_MAC)
            my_mac = v[47:0];
        else if (idx == REG_REPLIES_EN)
            reply_on = v[0];
    endtask

    task automatic add_field(input logic [47:0] v, input int nbytes);
        int i;
        for (i = nbytes - 1; i >= 0; i--)
            reply_img.push_back(v[8*i +: 8]);
    endtask

    function automatic status_t judge_frame();
        int   n;
        int   i;
        logic hit;
        n = (int'(ip_used) > MAX_IPS_DEF) ? MAX_IPS_DEF : int'(ip_used);
        hit = 1'b0;
        for (i = 0; i < n; i++)
            if (ip_tab[i] == cap_tpa)
                hit = 1'b1;
        if (rx_count < FRAME_LEN)
            return ST_SHORT;
        if (cap_etype != ETH_TYPE_ARP)
            return ST_NOT_ARP;
        if (cap_oper != ARP_OP_REQUEST)
            return ST_NOT_REQ;
        if (!hit)
            return ST_IP_MISS;
        if (!reply_on)
            return ST_DRY_RUN;
        return ST_REPLY;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic fin);
        status_t  verdict;
        tx_beat_t beat;
        int       k;
        // bytes past the ARP payload are dropped
        if (rx_count < FRAME_LEN)
        begin
            if (rx_count == OFS_ETYPE || rx_count == OFS_ETYPE + 1)
                cap_etype = {cap_etype[7:0], b};
            else if (rx_count == OFS_OPER || rx_count == OFS_OPER + 1)
                cap_oper = {cap_oper[7:0], b};
            else if (rx_count >= OFS_SHA && rx_count < OFS_SHA + 6)
                cap_sha = {cap_sha[39:0], b};
            else if (rx_count >= OFS_SPA && rx_count < OFS_SPA + 4)
                cap_spa = {cap_spa[23:0], b};
            else if (rx_count >= OFS_TPA)
                cap_tpa = {cap_tpa[23:0], b};
            rx_count++;
        end
        if (!fin)
            return;
        verdict  = judge_frame();
        rx_count = 0;
        if (verdict != ST_REPLY)
        begin
            beat.data = 8'h00;
            beat.code = verdict;
            beat.lst  = 1'b1;
            owed_beats.push_back(beat);
            refusals_seen++;
            return;
        end
        reply_img.delete();
        add_field(cap_sha, 6);
        add_field(my_mac, 6);
        add_field(ETH_TYPE_ARP, 2);
        add_field(ARP_HTYPE_ETH, 2);
        add_field(ARP_PTYPE_IPV4, 2);
        add_field(ARP_HLEN, 1);
        add_field(ARP_PLEN, 1);
        add_field(ARP_OP_REPLY, 2);
        add_field(my_mac, 6);
        add_field(cap_tpa, 4);
        add_field(cap_sha, 6);
        add_field(cap_spa, 4);
        for (k = 0; k < FRAME_LEN; k++)
        begin
            beat.data = reply_img[k];
            beat.code = ST_REPLY;
            beat.lst  = (k == FRAME_LEN - 1);
            owed_beats.push_back(beat);
        end
        replies_seen++;
    endtask

    task automatic check_beat();
        tx_beat_t want;
        if (owed_beats.size() == 0)
        begin
            errors++;
            $error("unexpected result beat: tx_byte %0h status %0d last %0b",
                   tx_byte, status, last);
            return;
        end
        want = owed_beats.pop_front();
        if (tx_byte !== want.data)
            mismatch("tx_byte", want.data, tx_byte);
        if (status !== want.code)
            mismatch("status", want.code, status);
        if (last !== want.lst)
            mismatch("last", want.lst, last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_tab        = '{default: 32'h0};
            ip_used       = 3'd0;
            my_mac        = 48'h0;
            reply_on      = 1'b1;
            rx_count      = 0;
            cap_etype     = 16'h0;
            cap_oper      = 16'h0;
            cap_sha       = 48'h0;
            cap_spa       = 32'h0;
            cap_tpa       = 32'h0;
            errors        = 0;
            replies_seen  = 0;
            refusals_seen = 0;
            owed_beats.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_reg(paddr[CFG_ADDR_W-1:3], pwdata);
            if (in_valid && in_ready)
                take_byte(rx_byte, frame_end);
            if (out_valid && out_ready)
                check_beat();
            pending <= owed_beats.size();
        end
    end

endmodule

### tb/tb_arp_proxy_responder.sv
// Top-level bench for the ARP proxy responder: clock, reset, register setup,
// frame stimulus with random idling and the final verdict.
// Depends on arpr_pkg, arp_proxy_responder and arp_proxy_checker.
module tb_arp_proxy_responder;
    import arpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RAND_BYTES  = 230;
    localparam int         WALK_FRAMES = 6;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    // walk order lines up with the register settings: the long frame meets dry run
    typedef enum int {
        K_REPLY,
        K_NOT_ARP,
        K_NOT_REQ,
        K_LONG,
        K_IP_MISS,
        K_SHORT,
        K_NOISE
    } frame_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  frame_end;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            tx_byte;
    logic [2:0]            status;
    logic                  last;

    int errors;
    int pending;
    int replies_seen;
    int refusals_seen;

    int send_idle    = 0;
    int recv_idle    = 0;
    int stalls_asked = 0;
    int stalls_done  = 0;
    int frames_sent  = 0;
    int bytes_sent   = 0;
    int settings_run = 0;

    logic [7:0]  frame_q[$];
    logic [31:0] cfg_entry[4];
    int          cfg_count;

    arp_proxy_responder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .status    (status),
        .last      (last)
    );

    arp_proxy_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .tx_byte       (tx_byte),
        .status        (status),
        .last          (last),
        .errors        (errors),
        .pending       (pending),
        .replies_seen  (replies_seen),
        .refusals_seen (refusals_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("arp_proxy_responder test failed");
        $finish;
    end

    // receiver: random back-pressure, plus a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_done < stalls_asked)
            begin
                stalls_done++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int active_count();
        return (cfg_count > MAX_IPS_DEF) ? MAX_IPS_DEF : cfg_count;
    endfunction

    function automatic logic ip_active(input logic [31:0] ip);
        int i;
        for (i = 0; i < active_count(); i++)
            if (cfg_entry[i] == ip)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] hit_ip();
        if (active_count() == 0)
            return $urandom;
        return cfg_entry[$urandom_range(0, active_count() - 1)];
    endfunction

    // a miss, often taken from an entry beyond the count
    function automatic logic [31:0] miss_ip();
        logic [31:0] ip;
        if (active_count() < 4 && $urandom_range(0, 1))
            ip = cfg_entry[$urandom_range(active_count(), 3)];
        else
            ip = $urandom;
        while (ip_active(ip))
            ip = $urandom;
        return ip;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int s);
        logic [31:0] ent[4];
        logic [47:0] mac;
        logic        on;
        int          cnt;
        int          i;
        for (i = 0; i < 4; i++)
            ent[i] = $urandom;
        mac = rand48();
        on  = 1'b1;
        cnt = 4;
        case (s)
            1:
            begin
                ent[0] = 32'hFFFF_FFFF;
                ent[1] = 32'h0;
                cnt    = 7;
                mac    = 48'hFFFF_FFFF_FFFF;
            end
            2:
            begin
                cnt = 2;
                mac = 48'h0;
            end
            3:
            begin
                cnt = 1;
                on  = 1'b0;
            end
            4:
                cnt = 0;
            default: ;
        endcase
        // junk in the unused upper bits must be ignored
        for (i = 0; i < 4; i++)
            reg_write(3'(REG_IP_ENTRY_0 + i), {32'($urandom), ent[i]});
        reg_write(REG_IP_COUNT, {32'($urandom), 29'($urandom), 3'(cnt)});
        reg_write(REG_REPLY_MAC, {16'($urandom), mac});
        reg_write(REG_REPLIES_EN, {32'($urandom), 31'($urandom), on});
        if (s == 2)
            reg_write(REG_UNUSED, {32'($urandom), 32'($urandom)});
        cfg_entry = ent;
        cfg_count = cnt;
        settings_run++;
    endtask

    task automatic append_field(input logic [47:0] v, input int nbytes);
        int i;
        for (i = nbytes - 1; i >= 0; i--)
            frame_q.push_back(v[8*i +: 8]);
    endtask

    task automatic build_frame(input frame_kind_t kind);
        logic [15:0] etype;
        logic [15:0] oper;
        logic [31:0] tip;
        int          i;
        int          len;
        etype = ETH_TYPE_ARP;
        oper  = ARP_OP_REQUEST;
        tip   = hit_ip();
        case (kind)
            K_NOT_ARP:
            begin
                case ($urandom_range(0, 2))
                    0: etype = ARP_PTYPE_IPV4;
                    1: etype = {ETH_TYPE_ARP[7:0], ETH_TYPE_ARP[15:8]};
                    default:
                    begin
                        etype = 16'($urandom);
                        while (etype == ETH_TYPE_ARP)
                            etype = 16'($urandom);
                    end
                endcase
            end
            K_NOT_REQ:
            begin
                case ($urandom_range(0, 3))
                    0: oper = ARP_OP_REPLY;
                    1: oper = 16'h0000;
                    2: oper = 16'hFFFF;
                    default:
                    begin
                        oper = 16'($urandom);
                        while (oper == ARP_OP_REQUEST)
                            oper = 16'($urandom);
                    end
                endcase
            end
            K_IP_MISS:
                tip = miss_ip();
            default: ;
        endcase
        frame_q.delete();
        append_field($urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : rand48(), 6);
        append_field(rand48(), 6);
        append_field(etype, 2);
        append_field(ARP_HTYPE_ETH, 2);
        append_field(ARP_PTYPE_IPV4, 2);
        append_field(ARP_HLEN, 1);
        append_field(ARP_PLEN, 1);
        append_field(oper, 2);
        append_field(rand48(), 6);
        append_field($urandom, 4);
        append_field($urandom_range(0, 1) ? 48'h0 : rand48(), 6);
        append_field(tip, 4);
        if (kind == K_NOISE)
            for (i = 0; i < frame_q.size(); i++)
                frame_q[i] = 8'($urandom);
        // trailing bytes past the payload, as padding would bring
        if (kind == K_LONG || kind == K_NOISE ||
            (kind == K_REPLY && $urandom_range(0, 3) == 0))
        begin
            len = $urandom_range(1, 8);
            for (i = 0; i < len; i++)
                frame_q.push_back(8'($urandom));
        end
        if (kind == K_SHORT)
        begin
            len = $urandom_range(1, FRAME_LEN - 1);
            while (frame_q.size() > len)
                void'(frame_q.pop_back());
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        frame_end <= fin;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // registers are only touched once the block has drained
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return K_REPLY;
        case (r)
            4:       return K_LONG;
            5:       return K_NOT_ARP;
            6:       return K_NOT_REQ;
            7:       return K_IP_MISS;
            8:       return K_SHORT;
            default: return K_NOISE;
        endcase
    endfunction

    initial
    begin
        int frame_no;
        int rand_start;
        int waited;
        int fails;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        frame_end <= 1'b0;
        cfg_entry  = '{default: 32'h0};
        cfg_count  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 19;
        recv_idle = 82;

        // runt frames under the reset configuration
        frame_q.delete();
        frame_q.push_back(8'hFF);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        frame_q.delete();
        frame_q.push_back(8'h55);
        frame_q.push_back(8'hAA);
        send_frame();

        // walk six frame kinds over the register settings in turn, then random kinds
        frame_no   = 0;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RAND_BYTES || frame_no < WALK_FRAMES)
        begin
            if (bytes_sent - rand_start < RAND_BYTES / 3)
            begin
                send_idle = 19;
                recv_idle = 82;
            end
            else if (bytes_sent - rand_start < 2 * RAND_BYTES / 3)
            begin
                send_idle = 82;
                recv_idle = 19;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            settle();
            apply_setting(frame_no % 5);
            build_frame((frame_no < WALK_FRAMES) ? frame_kind_t'(frame_no) : pick_kind());
            send_frame();
            frame_no++;
        end

        // long receiver hold-off: a reply sits in the output, the next frame end backs up
        settle();
        apply_setting(1);
        send_idle = 0;
        recv_idle = 0;
        stalls_asked++;
        build_frame(K_REPLY);
        send_frame();
        build_frame(K_SHORT);
        send_frame();

        in_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);

        fails = errors;
        if (pending != 0)
        begin
            $error("%0d result beats never arrived", pending);
            fails++;
        end
        $display("Sent %0d frames (%0d bytes) over %0d register settings;",
                 frames_sent, bytes_sent, settings_run);
        $display("checked %0d full replies and %0d status beats.",
                 replies_seen, refusals_seen);
        if (fails == 0)
            $display("arp_proxy_responder test passed");
        else
            $display("arp_proxy_responder test failed");
        $finish;
    end

endmodule

### files.f
rtl/core/arpr_pkg.sv
rtl/core/arpr_regs.sv
rtl/core/arpr_parse.sv
rtl/core/arpr_tx.sv
rtl/core/arp_proxy_responder.sv
tb/arp_proxy_checker.sv
tb/tb_arp_proxy_responder.sv
